// File: hw/rtl/csba_pkg.sv
package csba_pkg;

	localparam int WORD_BITS = 64;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [1:0] STATUS_BADREL  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_CHECK,
		ST_FREE,
		ST_RESP
	} state_t;

	// Summary of one map word as seen by the first-fit search.
	typedef struct packed {
		logic       inside_hit;
		logic [5:0] inside_pos;
		logic [6:0] lead_free;
		logic [6:0] trail_free;
	} eval_t;

endpackage

// File: hw/rtl/csba_if.sv
interface csba_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [12:0] count;
	logic [11:0] start_sector;

	modport source (output valid, output mode, output count, output start_sector, input ready);
	modport sink (input valid, input mode, input count, input start_sector, output ready);
endinterface

interface csba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] first_sector;

	modport source (output valid, output status, output first_sector, input ready);
	modport sink (input valid, input status, input first_sector, output ready);
endinterface

// File: hw/rtl/csba_ram.sv
module csba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/csba_word_eval.sv
module csba_word_eval (
	input  logic [63:0]     used,
	input  logic [6:0]      lim,
	input  logic [6:0]      cnt,
	input  logic            cnt_ok,
	output csba_pkg::eval_t res
);
	import csba_pkg::*;

	logic [63:0]      lim_mask;
	logic [63:0]      free_w;
	logic [6:0][63:0] runs;
	logic [63:0]      win;

	assign lim_mask = (lim >= 7'd64) ? {64{1'b1}} : ((64'd1 << lim[5:0]) - 64'd1);
	assign free_w   = ~used & lim_mask;

	// runs[k] marks positions that open 2**k free bits inside the word.
	always_comb begin
		runs[0] = free_w;
		for (int k = 1; k < 7; k++) begin
			runs[k] = runs[k-1] & (runs[k-1] >> (1 << (k - 1)));
		end
	end

	always_comb begin
		logic [6:0] acc;
		acc = 7'd0;
		win = {64{1'b1}};
		for (int k = 0; k < 7; k++) begin
			if (cnt[k]) begin
				win = win & (runs[k] >> acc);
				acc = acc + 7'(1 << k);
			end
		end
	end

	always_comb begin
		res.inside_hit = cnt_ok && (cnt != 7'd0) && (win != 64'd0);
		res.inside_pos = 6'd0;
		res.lead_free  = 7'd64;
		res.trail_free = 7'd64;
		for (int j = 63; j >= 0; j--) begin
			if (win[j]) begin
				res.inside_pos = 6'(j);
			end
			if (!free_w[j]) begin
				res.lead_free = 7'(j);
			end
		end
		for (int j = 0; j < 64; j++) begin
			if (!free_w[j]) begin
				res.trail_free = 7'(63 - j);
			end
		end
	end

endmodule

// File: hw/rtl/contiguous_sector_bitmap_allocator_core.sv
// First-fit sector allocator over a used/free bitmap held in one 64-bit wide
// synchronous RAM, one word per 64 sectors. After reset the block runs a
// clearing pass of one word per cycle that frees every sector except 0 and
// 1; no request is taken until it is done. An allocate scans the map word by
// word from sector 0, one RAM read per cycle, up to the last word of the
// active sector count, then does a read-modify-write of every word the found
// run touches. A release reads the words of its run once to check that all
// are used and a second time to clear them. Trivial requests (zero count, run
// too long, run past the end) go straight to the response. One request is
// worked on at a time; the next request transfer is taken while a finished
// result still waits in the output register.
module contiguous_sector_bitmap_allocator_core #(
	parameter int MAX_SECTORS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	csba_req_if.sink    req,
	csba_rsp_if.source  rsp
);
	import csba_pkg::*;

	localparam int WORDS = (MAX_SECTORS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NW    = $clog2(MAX_SECTORS + 1);
	localparam int W     = ((NW > 14) ? NW : 14) + 1;
	localparam logic [W-1:0] MAX_W     = W'(MAX_SECTORS);
	localparam logic [W-1:0] LAST_WORD = W'(WORDS - 1);

	state_t state_q, state_d;

	logic [12:0]  sector_count_q;
	logic [W-1:0] n_w, sc_w;

	logic [W-1:0] cnt_q, r_q, run_a_q, run_e_q;
	logic [W-1:0] iss_q, pass_end_q, waddr_s1, clr_q;
	logic         dv_s1;
	logic [1:0]   res_status_q;
	logic [11:0]  res_first_q;
	logic         out_valid_q;
	logic [1:0]   out_status_q;
	logic [11:0]  out_first_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	logic [W-1:0] cnt_in, start_in, rel_end_in, nw_last;
	logic         acc, out_free, issue, last_dv, in_pass;
	logic         too_big, rel_bad;

	logic [W-1:0] base_w, rem_w, carry_sum, found_first, found_end, new_r;
	logic [6:0]   lim7;
	logic         carry_hit, hit, check_bad;
	logic [63:0]  run_mask;
	logic [5:0]   lo, hi;
	eval_t        ev;

	// The active count is the register clipped to the map size.
	assign sc_w    = W'(sector_count_q);
	assign n_w     = (sc_w > MAX_W) ? MAX_W : sc_w;
	assign nw_last = ((n_w + W'(63)) >> 6) - W'(1);

	assign cnt_in     = W'(req.count);
	assign start_in   = W'(req.start_sector);
	assign rel_end_in = start_in + cnt_in;
	assign acc        = req.valid && req.ready;
	assign too_big    = cnt_in > n_w;
	assign rel_bad    = rel_end_in > n_w;
	assign out_free   = !out_valid_q || rsp.ready;

	assign in_pass = (state_q == ST_SCAN) || (state_q == ST_MARK) ||
	                 (state_q == ST_CHECK) || (state_q == ST_FREE);
	assign issue   = in_pass && (iss_q <= pass_end_q);
	assign last_dv = dv_s1 && (waddr_s1 == pass_end_q);

	// Search step on the word that the RAM presents this cycle. A run that
	// began in earlier words (r_q free sectors so far) wins over one that
	// lies wholly inside this word, since it ends first.
	assign base_w = W'({waddr_s1, 6'b0});
	assign rem_w  = n_w - base_w;
	assign lim7   = (rem_w >= W'(64)) ? 7'd64 : rem_w[6:0];

	csba_word_eval u_eval (
		.used   (ram_rdata),
		.lim    (lim7),
		.cnt    (cnt_q[6:0]),
		.cnt_ok (cnt_q <= W'(64)),
		.res    (ev)
	);

	assign carry_sum   = r_q + W'(ev.lead_free);
	assign carry_hit   = carry_sum >= cnt_q;
	assign hit         = carry_hit || ev.inside_hit;
	assign found_first = carry_hit ? (base_w - r_q) : (base_w + W'(ev.inside_pos));
	assign found_end   = found_first + cnt_q - W'(1);
	assign new_r       = (ev.lead_free == 7'd64) ? (r_q + W'(64)) : W'(ev.trail_free);

	// Bits of the current word that belong to the run being marked, checked
	// or freed.
	assign lo = (waddr_s1 == (run_a_q >> 6)) ? run_a_q[5:0] : 6'd0;
	assign hi = (waddr_s1 == (run_e_q >> 6)) ? run_e_q[5:0] : 6'd63;
	assign run_mask  = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
	assign check_bad = (ram_rdata & run_mask) != run_mask;

	csba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					if (req.mode == MODE_ALLOC) begin
						state_d = (too_big || cnt_in == '0) ? ST_RESP : ST_SCAN;
					end else begin
						state_d = (rel_bad || cnt_in == '0) ? ST_RESP : ST_CHECK;
					end
				end
			end
			ST_SCAN: begin
				if (dv_s1 && hit) begin
					state_d = ST_MARK;
				end else if (last_dv) begin
					state_d = ST_RESP;
				end
			end
			ST_CHECK: begin
				if (dv_s1 && check_bad) begin
					state_d = ST_RESP;
				end else if (last_dv) begin
					state_d = ST_FREE;
				end
			end
			ST_MARK, ST_FREE: begin
				if (last_dv) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready        = (state_q == ST_IDLE);
		rsp.valid        = out_valid_q;
		rsp.status       = out_status_q;
		rsp.first_sector = out_first_q;
		ram_re           = issue;
		ram_raddr        = iss_q[AW-1:0];
		ram_we           = 1'b0;
		ram_waddr        = waddr_s1[AW-1:0];
		ram_wdata        = ram_rdata | run_mask;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[AW-1:0];
				ram_wdata = (clr_q == '0) ? 64'd3 : 64'd0;
			end
			ST_MARK: begin
				ram_we = dv_s1;
			end
			ST_FREE: begin
				ram_we    = dv_s1;
				ram_wdata = ram_rdata & ~run_mask;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			sector_count_q <= 13'd4096;
			clr_q          <= '0;
			dv_s1          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sector_count_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + W'(1);
			end
			// A read still in flight from a finished pass is dropped.
			dv_s1 <= issue && (state_d == state_q);
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers. The read address steps only while the pass goes
	// on; a change of state either ends the pass or loads a new start word.
	always_ff @(posedge clk) begin
		if (issue && (state_d == state_q)) begin
			iss_q <= iss_q + W'(1);
		end
		waddr_s1 <= iss_q;
		if (state_q == ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_first_q  <= res_first_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cnt_q       <= cnt_in;
					r_q         <= '0;
					run_a_q     <= start_in;
					run_e_q     <= rel_end_in - W'(1);
					res_first_q <= 12'd0;
					if (req.mode == MODE_ALLOC) begin
						res_status_q <= too_big ? STATUS_NOSPACE : STATUS_OK;
						iss_q        <= '0;
						pass_end_q   <= nw_last;
					end else begin
						res_status_q <= rel_bad ? STATUS_BADREL : STATUS_OK;
						iss_q        <= start_in >> 6;
						pass_end_q   <= (rel_end_in - W'(1)) >> 6;
					end
				end
			end
			ST_SCAN: begin
				if (dv_s1) begin
					if (hit) begin
						res_first_q <= found_first[11:0];
						run_a_q     <= found_first;
						run_e_q     <= found_end;
						iss_q       <= found_first >> 6;
						pass_end_q  <= found_end >> 6;
					end else begin
						r_q <= new_r;
						if (last_dv) begin
							res_status_q <= STATUS_NOSPACE;
						end
					end
				end
			end
			ST_CHECK: begin
				if (dv_s1 && check_bad) begin
					res_status_q <= STATUS_BADREL;
				end else if (last_dv) begin
					iss_q <= run_a_q >> 6;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/csba_checker.sv
module csba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [11:0] rsp_first_sector
);
	import csba_pkg::*;

	// A request transfer starts work, so no second one follows at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken on two cycles in a row");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NOSPACE ||
		               rsp_status == STATUS_BADREL))
		else $error("undefined status code");

	// Failed requests never report a sector.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != STATUS_OK) |-> (rsp_first_sector == 12'd0))
		else $error("failed request reports a sector");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_status) && $stable(rsp_first_sector)))
		else $error("stalled result changed");

endmodule

bind contiguous_sector_bitmap_allocator_core csba_checker u_csba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_first_sector (rsp.first_sector)
);
